/* design/ths_pkg.sv */
// shared types, codes and helpers for the timer heap scheduler
`default_nettype none

package ths_pkg;

  localparam int unsigned DueW    = 63;
  localparam int unsigned PeriodW = 40;
  localparam int unsigned IdW     = 8;
  // most fired beats one tick may produce
  localparam int unsigned MaxResults = 16;

  typedef enum logic [0:0] {
    OP_INSERT = 1'b0,
    OP_TICK   = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    KIND_ACCEPT = 2'd0,
    KIND_FULL   = 2'd1,
    KIND_ZERO   = 2'd2,
    KIND_FIRED  = 2'd3
  } kind_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SU_RD,
    ST_SU_CMP,
    ST_POP_CHK,
    ST_POP_ROOT,
    ST_POP_LAST,
    ST_SD_RD,
    ST_SD_L,
    ST_SD_R,
    ST_RELOAD,
    ST_EMIT
  } state_e;

  // one heap slot
  typedef struct packed {
    logic [DueW-1:0]    due;
    logic [PeriodW-1:0] period;
    logic               periodic;
    logic [IdW-1:0]     id;
  } entry_t;

  // one result beat without the last flag
  typedef struct packed {
    kind_e           kind;
    logic [IdW-1:0]  id;
    logic [DueW-1:0] due;
  } res_t;

  // time plus interval, clipped at the largest 63-bit time
  function automatic logic [DueW-1:0] sat_add(input logic [DueW-1:0] a,
                                              input logic [PeriodW-1:0] b);
    logic [DueW:0] sum;
    sum = {1'b0, a} + (DueW+1)'(b);
    return sum[DueW] ? {DueW{1'b1}} : sum[DueW-1:0];
  endfunction

endpackage

`default_nettype wire

/* design/ths_in_if.sv */
// input channel: insert and tick beats
`default_nettype none

interface ths_in_if;
  import ths_pkg::*;

  logic               valid;
  logic               ready;
  logic               operation;
  logic [IdW-1:0]     timer_id;
  logic [PeriodW-1:0] interval_ns;
  logic               periodic;
  logic [DueW-1:0]    now_ns;

  modport source (output valid, operation, timer_id, interval_ns, periodic, now_ns,
                  input ready);
  modport sink (input valid, operation, timer_id, interval_ns, periodic, now_ns,
                output ready);
endinterface

`default_nettype wire

/* design/ths_out_if.sv */
// output channel: result beats
`default_nettype none

interface ths_out_if;
  import ths_pkg::*;

  logic            valid;
  logic            ready;
  logic [1:0]      kind;
  logic [IdW-1:0]  fired_timer_id;
  logic [DueW-1:0] due_time_ns;
  logic            last;

  modport source (output valid, kind, fired_timer_id, due_time_ns, last, input ready);
  modport sink (input valid, kind, fired_timer_id, due_time_ns, last, output ready);
endinterface

`default_nettype wire

/* design/timer_heap_scheduler_top.sv */
// Timer queue held as a binary min-heap in a single-port-read synchronous memory.
//
// in_i carries insert beats (timer id, interval, periodic flag) and tick beats
// (current time). out_o returns result beats; each input yields its beats with
// last set on the final one. An insert always yields one beat (accepted, full or
// zero period). A tick yields one fired beat per expired entry, none if nothing is due.
// A tick fires at most MaxResults entries. The heap lives in one memory with a
// registered read, walked by a read-compare-write sequencer, one heap level per step.
// Insert: per sift-up level, read the parent, then compare and move it down.
// Tick: test the root, then per fired entry pop it and sift the last entry down
// level by level, plus a sift-up when the entry reloads.
// The memory port takes one access per cycle.
// One item is in work at a time; in_i.ready is high only when the sequencer is idle.
// A result sits in an output register; the next item is accepted while it waits.
// If out_o stalls, the sequencer holds before overwriting a waiting beat.
// Reset empties the heap and sets the current time to zero; memory contents are
// not cleared, only slots below the entry count are ever read.
`default_nettype none

module timer_heap_scheduler_top #(
  parameter int unsigned CAPACITY = 16
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  ths_in_if.sink     in_i,
  ths_out_if.source  out_o
);
  import ths_pkg::*;

  localparam int unsigned IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned XW = IW + 2;

  state_e          state_q, state_d;
  logic [CW-1:0]   count_q, count_d;
  logic [DueW-1:0] cur_q, cur_d;
  logic [CW-1:0]   limit_q, limit_d;
  logic [CW-1:0]   n_q, n_d;
  logic [IW-1:0]   idx_q, idx_d;
  entry_t          x_q, x_d;
  entry_t          top_q, top_d;
  entry_t          best_q, best_d;
  logic [IW-1:0]   best_idx_q, best_idx_d;
  logic            best_self_q, best_self_d;
  res_t            res_q, res_d;
  logic            pend_v_q, pend_v_d;
  logic            tick_q, tick_d;

  // memory port signals
  entry_t          mem [CAPACITY];
  entry_t          rdata_q;
  logic            mem_we, mem_re;
  logic [IW-1:0]   mem_waddr, mem_raddr;
  entry_t          mem_wdata;

  // output register
  logic            out_valid_q;
  res_t            out_q;
  logic            out_last_q;
  logic            out_load;
  res_t            out_n;
  logic            out_last_n;
  logic            slot_free;

  // heap index helpers
  logic [XW-1:0]   lchild, rchild, count_ext;
  logic [IW-1:0]   parent;
  logic [DueW-1:0] ins_due;
  logic            l_less;

  assign lchild    = XW'({idx_q, 1'b1});
  assign rchild    = lchild + XW'(1);
  assign count_ext = XW'(count_q);
  assign parent    = (idx_q - IW'(1)) >> 1;
  assign ins_due   = sat_add(cur_q, in_i.interval_ns);
  assign l_less    = rdata_q.due < x_q.due;
  assign slot_free = !out_valid_q || out_o.ready;

  assign in_i.ready = (state_q == ST_IDLE);

  // heap memory, registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem[mem_raddr];
    end
  end

  // sequencer next state
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    cur_d       = cur_q;
    limit_d     = limit_q;
    n_d         = n_q;
    idx_d       = idx_q;
    x_d         = x_q;
    top_d       = top_q;
    best_d      = best_q;
    best_idx_d  = best_idx_q;
    best_self_d = best_self_q;
    res_d       = res_q;
    pend_v_d    = pend_v_q;
    tick_d      = tick_q;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_waddr   = idx_q;
    mem_raddr   = '0;
    mem_wdata   = x_q;
    out_load    = 1'b0;
    out_n       = res_q;
    out_last_n  = 1'b1;

    unique case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          if (in_i.operation == OP_TICK) begin
            cur_d    = in_i.now_ns;
            limit_d  = (32'(count_q) < MaxResults) ? count_q : CW'(MaxResults);
            n_d      = '0;
            pend_v_d = 1'b0;
            tick_d   = 1'b1;
            state_d  = ST_POP_CHK;
          end else begin
            res_d.id  = in_i.timer_id;
            res_d.due = ins_due;
            tick_d    = 1'b0;
            if (in_i.periodic && (in_i.interval_ns == '0)) begin
              res_d.kind = KIND_ZERO;
              state_d    = ST_EMIT;
            end else if (count_q >= CW'(CAPACITY)) begin
              res_d.kind = KIND_FULL;
              state_d    = ST_EMIT;
            end else begin
              res_d.kind = KIND_ACCEPT;
              x_d        = '{due: ins_due, period: in_i.interval_ns,
                             periodic: in_i.periodic, id: in_i.timer_id};
              idx_d      = count_q[IW-1:0];
              state_d    = ST_SU_RD;
            end
          end
        end
      end

      // sift-up: fetch parent of the hole, or write the element at the root
      ST_SU_RD: begin
        if (idx_q == '0) begin
          mem_we  = 1'b1;
          count_d = count_q + CW'(1);
          state_d = tick_q ? ST_POP_CHK : ST_EMIT;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = parent;
          state_d   = ST_SU_CMP;
        end
      end

      // sift-up: stop or move parent down into the hole
      ST_SU_CMP: begin
        mem_we = 1'b1;
        if (rdata_q.due <= x_q.due) begin
          count_d = count_q + CW'(1);
          state_d = tick_q ? ST_POP_CHK : ST_EMIT;
        end else begin
          mem_wdata = rdata_q;
          idx_d     = parent;
          state_d   = ST_SU_RD;
        end
      end

      // tick: fetch the root if more may fire
      ST_POP_CHK: begin
        if ((n_q < limit_q) && (count_q != '0)) begin
          mem_re  = 1'b1;
          state_d = ST_POP_ROOT;
        end else begin
          state_d = pend_v_q ? ST_EMIT : ST_IDLE;
        end
      end

      // tick: fire the root if due, flushing the previous fired beat
      ST_POP_ROOT: begin
        if (rdata_q.due <= cur_q) begin
          if (!pend_v_q || slot_free) begin
            out_load   = pend_v_q;
            out_last_n = 1'b0;
            res_d      = '{kind: KIND_FIRED, id: rdata_q.id, due: rdata_q.due};
            pend_v_d   = 1'b1;
            top_d      = rdata_q;
            n_d        = n_q + CW'(1);
            count_d    = count_q - CW'(1);
            if (count_q == CW'(1)) begin
              state_d = ST_RELOAD;
            end else begin
              mem_re    = 1'b1;
              mem_raddr = IW'(count_q - CW'(1));
              state_d   = ST_POP_LAST;
            end
          end
        end else begin
          state_d = pend_v_q ? ST_EMIT : ST_IDLE;
        end
      end

      // tick: last entry becomes the element sifted down from the root
      ST_POP_LAST: begin
        x_d     = rdata_q;
        idx_d   = '0;
        state_d = ST_SD_RD;
      end

      // sift-down: fetch left child or settle
      ST_SD_RD: begin
        if (lchild >= count_ext) begin
          mem_we  = 1'b1;
          state_d = ST_RELOAD;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = lchild[IW-1:0];
          state_d   = ST_SD_L;
        end
      end

      // sift-down: left child against the element
      ST_SD_L: begin
        best_self_d = !l_less;
        best_d      = l_less ? rdata_q : x_q;
        best_idx_d  = lchild[IW-1:0];
        if (rchild < count_ext) begin
          mem_re    = 1'b1;
          mem_raddr = rchild[IW-1:0];
          state_d   = ST_SD_R;
        end else begin
          mem_we = 1'b1;
          if (l_less) begin
            mem_wdata = rdata_q;
            idx_d     = lchild[IW-1:0];
            state_d   = ST_SD_RD;
          end else begin
            state_d = ST_RELOAD;
          end
        end
      end

      // sift-down: right child against the current pick
      ST_SD_R: begin
        mem_we = 1'b1;
        if (rdata_q.due < best_q.due) begin
          mem_wdata = rdata_q;
          idx_d     = rchild[IW-1:0];
          state_d   = ST_SD_RD;
        end else if (best_self_q) begin
          state_d = ST_RELOAD;
        end else begin
          mem_wdata = best_q;
          idx_d     = best_idx_q;
          state_d   = ST_SD_RD;
        end
      end

      // tick: push a periodic entry back
      ST_RELOAD: begin
        if (top_q.periodic) begin
          x_d     = '{due: sat_add(cur_q, top_q.period), period: top_q.period,
                      periodic: 1'b1, id: top_q.id};
          idx_d   = count_q[IW-1:0];
          state_d = ST_SU_RD;
        end else begin
          state_d = ST_POP_CHK;
        end
      end

      // final beat of an item
      ST_EMIT: begin
        if (slot_free) begin
          out_load = 1'b1;
          pend_v_d = 1'b0;
          state_d  = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      count_q  <= '0;
      cur_q    <= '0;
      pend_v_q <= 1'b0;
      tick_q   <= 1'b0;
      limit_q  <= '0;
      n_q      <= '0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      cur_q    <= cur_d;
      pend_v_q <= pend_v_d;
      tick_q   <= tick_d;
      limit_q  <= limit_d;
      n_q      <= n_d;
    end
  end

  // working payload registers
  always_ff @(posedge clk_i) begin
    idx_q       <= idx_d;
    x_q         <= x_d;
    top_q       <= top_d;
    best_q      <= best_d;
    best_idx_q  <= best_idx_d;
    best_self_q <= best_self_d;
    res_q       <= res_d;
  end

  // output beat register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q      <= out_n;
      out_last_q <= out_last_n;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.kind           = out_q.kind;
  assign out_o.fired_timer_id = out_q.id;
  assign out_o.due_time_ns    = out_q.due;
  assign out_o.last           = out_last_q;

  // the entry count never passes the heap size
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(CAPACITY))
    else $error("entry count above capacity");

  // no read and write of the same slot in one cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
    else $error("memory read and write collide");

  // a fired beat never carries a due time after the tick time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> ((out_o.kind != KIND_FIRED) || (out_o.due_time_ns <= cur_q)))
    else $error("fired entry not yet due");

  // no fired beat is left behind when the sequencer goes idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !pend_v_q)
    else $error("pending beat dropped");

endmodule

`default_nettype wire

/* bench/timer_heap_scheduler_top_test.sv */
// self-checking bench for the timer heap scheduler: directed table, then random traffic
`timescale 1ns / 1ps

module timer_heap_scheduler_top_test;
  import ths_pkg::*;

  localparam int unsigned        HeapSlots  = 16;
  localparam logic [DueW-1:0]    TimeMax    = '1;
  localparam logic [PeriodW-1:0] IntervalMax = '1;
  localparam int unsigned        DirRows    = 25;
  localparam int unsigned        RandItems  = 155;
  localparam int unsigned        ErrShown   = 40;

  // one input beat
  typedef struct packed {
    op_e                op;
    logic [IdW-1:0]     id;
    logic [PeriodW-1:0] interval;
    logic               periodic;
    logic [DueW-1:0]    now;
  } item_t;

  // one result beat
  typedef struct packed {
    kind_e           kind;
    logic [IdW-1:0]  id;
    logic [DueW-1:0] due;
    logic            last;
  } result_t;

  // directed row: item plus an optional hand-written result
  typedef struct packed {
    item_t   item;
    logic    has_want;
    result_t want;
  } stim_row_t;

  logic clk;
  logic rst_n;

  ths_in_if  in_bus ();
  ths_out_if out_bus ();

  timer_heap_scheduler_top #(
    .CAPACITY(HeapSlots)
  ) i_dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_bus),
    .out_o (out_bus)
  );

  // shadow heap
  logic [DueW-1:0]    sh_due    [HeapSlots];
  logic [PeriodW-1:0] sh_period [HeapSlots];
  logic               sh_periodic[HeapSlots];
  logic [IdW-1:0]     sh_id     [HeapSlots];
  int unsigned        sh_count;
  logic [DueW-1:0]    sh_time;

  result_t     awaited_results[$];
  stim_row_t   dir_rows[DirRows];
  int unsigned fail_count;
  int unsigned items_sent;
  int unsigned results_checked;
  int unsigned fired_seen;
  int unsigned burst_left;

  // clock
  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // due time with saturation at the top of the 63-bit range
  function automatic logic [DueW-1:0] clip_due(input logic [DueW-1:0] base,
                                              input logic [PeriodW-1:0] delta);
    logic [DueW:0] total;
    total = {1'b0, base} + {{(DueW+1-PeriodW){1'b0}}, delta};
    if (total > {1'b0, TimeMax}) return TimeMax;
    return total[DueW-1:0];
  endfunction

  function automatic void slot_swap(input int unsigned a, input int unsigned b);
    logic [DueW-1:0]    d;
    logic [PeriodW-1:0] p;
    logic               f;
    logic [IdW-1:0]     n;
    d = sh_due[a]; p = sh_period[a]; f = sh_periodic[a]; n = sh_id[a];
    sh_due[a] = sh_due[b]; sh_period[a] = sh_period[b];
    sh_periodic[a] = sh_periodic[b]; sh_id[a] = sh_id[b];
    sh_due[b] = d; sh_period[b] = p; sh_periodic[b] = f; sh_id[b] = n;
  endfunction

  // climb while the parent is strictly later
  function automatic void heap_climb(input int unsigned start);
    int unsigned i;
    int unsigned par;
    i = start;
    while (i > 0) begin
      par = (i - 1) / 2;
      if (sh_due[par] <= sh_due[i]) break;
      slot_swap(par, i);
      i = par;
    end
  endfunction

  // sink toward the strictly earliest child, left checked first
  function automatic void heap_sink(input int unsigned start);
    int unsigned i;
    int unsigned lc;
    int unsigned rc;
    int unsigned pick;
    i = start;
    while (1'b1) begin
      lc = 2 * i + 1;
      rc = lc + 1;
      pick = i;
      if (lc < sh_count && sh_due[lc] < sh_due[pick]) pick = lc;
      if (rc < sh_count && sh_due[rc] < sh_due[pick]) pick = rc;
      if (pick == i) break;
      slot_swap(i, pick);
      i = pick;
    end
  endfunction

  function automatic void heap_insert(input logic [DueW-1:0] due,
                                      input logic [PeriodW-1:0] period,
                                      input logic per, input logic [IdW-1:0] id);
    if (sh_count >= HeapSlots) return;
    sh_due[sh_count] = due;
    sh_period[sh_count] = period;
    sh_periodic[sh_count] = per;
    sh_id[sh_count] = id;
    heap_climb(sh_count);
    sh_count++;
  endfunction

  // results one item causes, with the shadow heap advanced
  function automatic void heap_predict(input item_t it, output result_t res[$]);
    logic [DueW-1:0] due;
    int unsigned     limit;
    result_t         r;
    res.delete();
    if (it.op == OP_INSERT) begin
      due = clip_due(sh_time, it.interval);
      r.id = it.id;
      r.due = due;
      r.last = 1'b1;
      if (it.periodic && it.interval == '0) begin
        r.kind = KIND_ZERO;
      end else if (sh_count >= HeapSlots) begin
        r.kind = KIND_FULL;
      end else begin
        heap_insert(due, it.interval, it.periodic, it.id);
        r.kind = KIND_ACCEPT;
      end
      res.push_back(r);
    end else begin
      limit = (sh_count < MaxResults) ? sh_count : MaxResults;
      sh_time = it.now;
      while (res.size() < limit && sh_count > 0 && sh_due[0] <= it.now) begin
        logic [PeriodW-1:0] per_len;
        logic               per_flag;
        r.kind = KIND_FIRED;
        r.id = sh_id[0];
        r.due = sh_due[0];
        r.last = 1'b0;
        per_len = sh_period[0];
        per_flag = sh_periodic[0];
        sh_count--;
        sh_due[0] = sh_due[sh_count];
        sh_period[0] = sh_period[sh_count];
        sh_periodic[0] = sh_periodic[sh_count];
        sh_id[0] = sh_id[sh_count];
        heap_sink(0);
        res.push_back(r);
        if (per_flag) heap_insert(clip_due(it.now, per_len), per_len, per_flag, r.id);
      end
      if (res.size() > 0) res[res.size()-1].last = 1'b1;
    end
  endfunction

  function automatic stim_row_t row_plain(input op_e op, input logic [IdW-1:0] id,
                                          input logic [PeriodW-1:0] iv, input logic per,
                                          input logic [DueW-1:0] now);
    stim_row_t row;
    row = '0;
    row.item = '{op: op, id: id, interval: iv, periodic: per, now: now};
    row.has_want = 1'b0;
    return row;
  endfunction

  function automatic stim_row_t row_want(input logic [IdW-1:0] id,
                                         input logic [PeriodW-1:0] iv, input logic per,
                                         input kind_e kind, input logic [DueW-1:0] due);
    stim_row_t row;
    row = row_plain(OP_INSERT, id, iv, per, '0);
    row.has_want = 1'b1;
    row.want = '{kind: kind, id: id, due: due, last: 1'b1};
    return row;
  endfunction

  // drive one beat, wait for acceptance, then book its results
  task automatic send_item(input item_t it, input logic has_want, input result_t want);
    result_t calc[$];
    int unsigned gap;
    in_bus.valid       <= 1'b1;
    in_bus.operation   <= it.op;
    in_bus.timer_id    <= it.id;
    in_bus.interval_ns <= it.interval;
    in_bus.periodic    <= it.periodic;
    in_bus.now_ns      <= it.now;
    do @(posedge clk); while (in_bus.ready !== 1'b1);
    heap_predict(it, calc);
    if (has_want) awaited_results.push_back(want);
    else foreach (calc[k]) awaited_results.push_back(calc[k]);
    items_sent++;
    // bursts with random gaps, now and then a long pause
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 8);
      if ($urandom_range(0, 19) == 0) gap = $urandom_range(15, 40);
      if (gap > 0) begin
        in_bus.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
  endtask

  // receiver: quiet phases and stall-heavy phases
  initial begin
    int unsigned stall_left;
    int unsigned phase_left;
    logic        heavy;
    out_bus.ready <= 1'b0;
    stall_left = 0;
    phase_left = 0;
    heavy = 1'b0;
    forever begin
      @(posedge clk);
      if (phase_left == 0) begin
        heavy = ~heavy;
        phase_left = $urandom_range(40, 160);
      end
      phase_left--;
      if (stall_left > 0) begin
        out_bus.ready <= 1'b0;
        stall_left--;
      end else begin
        out_bus.ready <= 1'b1;
        if (heavy && $urandom_range(0, 3) == 0) stall_left = $urandom_range(1, 12);
      end
    end
  end

  // compare each accepted result beat with the oldest booked one
  always @(posedge clk) begin : check_out
    result_t want;
    if (rst_n && out_bus.valid === 1'b1 && out_bus.ready === 1'b1) begin
      if (out_bus.kind == KIND_FIRED) fired_seen++;
      if (awaited_results.size() == 0) begin
        fail_count++;
        if (fail_count <= ErrShown)
          $error("result beat with nothing booked: kind %0d id %0d due %0d",
                 out_bus.kind, out_bus.fired_timer_id, out_bus.due_time_ns);
      end else begin
        want = awaited_results.pop_front();
        results_checked++;
        if (out_bus.kind !== want.kind) begin
          fail_count++;
          if (fail_count <= ErrShown)
            $error("kind: expected %0d actual %0d", want.kind, out_bus.kind);
        end
        if (out_bus.fired_timer_id !== want.id) begin
          fail_count++;
          if (fail_count <= ErrShown)
            $error("fired_timer_id: expected %0d actual %0d", want.id,
                   out_bus.fired_timer_id);
        end
        if (out_bus.due_time_ns !== want.due) begin
          fail_count++;
          if (fail_count <= ErrShown)
            $error("due_time_ns: expected %0d actual %0d", want.due, out_bus.due_time_ns);
        end
        if (out_bus.last !== want.last) begin
          fail_count++;
          if (fail_count <= ErrShown)
            $error("last: expected %0d actual %0d", want.last, out_bus.last);
        end
      end
    end
  end

  // stimulus
  initial begin
    item_t           it;
    logic [DueW-1:0] tb_now;
    logic [63:0]     wide;
    int unsigned     pick;
    rst_n <= 1'b0;
    in_bus.valid       <= 1'b0;
    in_bus.operation   <= OP_INSERT;
    in_bus.timer_id    <= '0;
    in_bus.interval_ns <= '0;
    in_bus.periodic    <= 1'b0;
    in_bus.now_ns      <= '0;
    fail_count = 0;
    items_sent = 0;
    results_checked = 0;
    fired_seen = 0;
    burst_left = 1;
    sh_count = 0;
    sh_time = '0;

    // empty tick, first inserts, zero period, widest interval
    dir_rows[0]  = row_plain(OP_TICK, 8'h00, '0, 1'b0, '0);
    dir_rows[1]  = row_want(8'hFF, '0, 1'b0, KIND_ACCEPT, '0);
    dir_rows[2]  = row_want(8'h01, '0, 1'b1, KIND_ZERO, '0);
    dir_rows[3]  = row_want(8'h02, IntervalMax, 1'b1, KIND_ACCEPT,
                            {{(DueW-PeriodW){1'b0}}, IntervalMax});
    dir_rows[4]  = row_plain(OP_TICK, 8'h00, '0, 1'b0, '0);
    // latest time: reload saturates, then a saturated insert and a step back in time
    dir_rows[5]  = row_plain(OP_TICK, 8'h00, '0, 1'b0, TimeMax);
    dir_rows[6]  = row_want(8'h03, 40'd5, 1'b0, KIND_ACCEPT, TimeMax);
    dir_rows[7]  = row_plain(OP_TICK, 8'h00, '0, 1'b0, 63'd5);
    // fill the heap, ties included
    dir_rows[8]  = row_plain(OP_INSERT, 8'h10, 40'd100, 1'b0, '0);
    dir_rows[9]  = row_plain(OP_INSERT, 8'h11, 40'd50, 1'b0, '0);
    dir_rows[10] = row_plain(OP_INSERT, 8'h12, 40'd100, 1'b0, '0);
    dir_rows[11] = row_plain(OP_INSERT, 8'h13, 40'd7, 1'b1, '0);
    dir_rows[12] = row_plain(OP_INSERT, 8'h14, 40'd0, 1'b0, '0);
    dir_rows[13] = row_plain(OP_INSERT, 8'h15, 40'd50, 1'b0, '0);
    dir_rows[14] = row_plain(OP_INSERT, 8'h16, 40'd3000, 1'b0, '0);
    dir_rows[15] = row_plain(OP_INSERT, 8'h17, 40'd1, 1'b0, '0);
    dir_rows[16] = row_plain(OP_INSERT, 8'h18, 40'd100, 1'b0, '0);
    dir_rows[17] = row_plain(OP_INSERT, 8'h19, 40'hAA_AAAA_AAAA, 1'b0, '0);
    dir_rows[18] = row_plain(OP_INSERT, 8'h1A, 40'h55_5555_5555, 1'b0, '0);
    dir_rows[19] = row_plain(OP_INSERT, 8'h1B, 40'd2, 1'b0, '0);
    dir_rows[20] = row_plain(OP_INSERT, 8'h1C, 40'd100, 1'b0, '0);
    dir_rows[21] = row_plain(OP_INSERT, 8'h1D, 40'd9, 1'b0, '0);
    // full heap, and zero period taking precedence over full
    dir_rows[22] = row_want(8'h80, 40'd10, 1'b0, KIND_FULL, 63'd15);
    dir_rows[23] = row_want(8'h81, '0, 1'b1, KIND_ZERO, 63'd5);
    // everything due: fire limit reached
    dir_rows[24] = row_plain(OP_TICK, 8'h00, '0, 1'b0, TimeMax);

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[r])
      send_item(dir_rows[r].item, dir_rows[r].has_want, dir_rows[r].want);

    // random traffic: mostly advancing time, some jumps and steps back
    tb_now = '0;
    repeat (RandItems) begin
      wide = {$urandom, $urandom};
      it.id = IdW'($urandom_range(0, 255));
      it.now = wide[DueW-1:0];
      wide = {$urandom, $urandom};
      it.interval = wide[PeriodW-1:0];
      it.periodic = 1'($urandom_range(0, 1));
      if ($urandom_range(0, 99) < 55) begin
        it.op = OP_INSERT;
        pick = $urandom_range(0, 99);
        if (pick < 75) it.interval = PeriodW'($urandom_range(1, 3000));
        else if (pick < 87) it.interval = '0;
        it.periodic = ($urandom_range(0, 99) < 15);
      end else begin
        it.op = OP_TICK;
        pick = $urandom_range(0, 99);
        if (pick < 85) tb_now = tb_now + DueW'($urandom_range(0, 2500));
        else if (pick < 92) tb_now = wide[DueW-1:0] ^ DueW'({$urandom, $urandom});
        else if (pick < 94) tb_now = TimeMax;
        else tb_now = (tb_now > 63'd5000) ? tb_now - DueW'($urandom_range(0, 5000)) : '0;
        it.now = tb_now;
      end
      send_item(it, 1'b0, '0);
    end
    in_bus.valid <= 1'b0;

    while (awaited_results.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);

    $display("%0d items sent (%0d from the table), %0d result beats checked, %0d fired",
             items_sent, DirRows, results_checked, fired_seen);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

/* filelist.f */
design/ths_pkg.sv
design/ths_in_if.sv
design/ths_out_if.sv
design/timer_heap_scheduler_top.sv
bench/timer_heap_scheduler_top_test.sv
